// ===== hdl/p2a_pkg.sv =====
package p2a_pkg;

  // field widths
  localparam int PW = 17;  // pressure and sea level pressure
  localparam int TW = 15;  // reference temperature
  localparam int GW = 21;  // ground offset
  localparam int OW = 24;  // altitude outputs
  localparam int EW = 5;   // exponent of a 17-bit integer log

  // register map (word index)
  localparam logic [1:0] REG_SLP  = 2'd0;
  localparam logic [1:0] REG_TREF = 2'd1;
  localparam logic [1:0] REG_GOFF = 2'd2;

  localparam logic [PW-1:0] SLP_RST  = 17'd101325;
  localparam logic [TW-1:0] TREF_RST = 15'd1500;
  localparam logic [GW-1:0] GOFF_RST = 21'd0;

  // 0.190295 in Q30
  localparam logic [27:0] K_EXP = 28'd204327654;
  localparam int EXP_SHIFT = 30;

  localparam int KELVIN_OFS = 27315;
  localparam int CM_SCALE   = 2000;

  // n / 13 == (n * DIV13_MAGIC) >> DIV13_SHIFT for any 32-bit n
  localparam logic [31:0] DIV13_MAGIC = 32'h4EC4EC4F;
  localparam int DIV13_SHIFT = 34;

  localparam int ABS_LO = -200000;
  localparam int ABS_HI = 5000000;
  localparam int REL_LO = -5000000;
  localparam int REL_HI = 5000000;

  localparam logic [63:0] ONE30 = 64'd1 << 30;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + q/2^30) in Q(f) by repeated squaring, truncated
  function automatic logic [63:0] lt_from_q(input logic [63:0] q, input int f);
    logic [63:0] x;
    logic [63:0] r;
    x = ONE30 + q;
    r = '0;
    for (int k = 23; k >= 0; k--) begin
      if (k < f) begin
        x = (x * x) >> 30;
        if (x >= 2 * ONE30) begin
          x = x >> 1;
          r = r | (64'd1 << k);
        end
      end
    end
    return r;
  endfunction

  // 2^(q/2^30) in Q(f) as a product of 2^(2^-k) roots
  function automatic logic [63:0] et_from_q(input logic [63:0] q, input int f);
    logic [63:0] rt [0:30];
    logic [63:0] y;
    rt[0] = 2 * ONE30;
    for (int k = 1; k <= 30; k++) rt[k] = isqrt64(rt[k-1] << 30);
    y = ONE30;
    for (int k = 1; k <= 30; k++) begin
      if (q[30-k]) y = (y * rt[k]) >> 30;
    end
    return y >> (30 - f);
  endfunction

endpackage

// ===== hdl/p2a_log2.sv =====
module p2a_log2 #(
  parameter int LOG_TABLE_ENTRIES = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic [p2a_pkg::PW-1:0]            v,
  output logic [FRAC_BITS+p2a_pkg::EW-1:0]  log_out
);
  import p2a_pkg::*;

  localparam int AW = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int LW = FRAC_BITS + EW;
  localparam logic [AW-1:0] NV = AW'(LOG_TABLE_ENTRIES);

  logic [FRAC_BITS:0] lt_rom [0:LOG_TABLE_ENTRIES];

  for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_lt
    localparam logic [63:0] Q = (64'(gi) << 30) / LOG_TABLE_ENTRIES;
    localparam logic [63:0] VAL = (gi == LOG_TABLE_ENTRIES) ?
                                  (64'd1 << FRAC_BITS) : lt_from_q(Q, FRAC_BITS);
    assign lt_rom[gi] = VAL[FRAC_BITS:0];
  end

  // stage 1: normalize
  logic [EW-1:0]   e_nxt;
  logic [PW+31:0]  sh;
  logic [EW-1:0]   e1_r;
  logic [31:0]     f1_r;

  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (v[i]) e_nxt = EW'(i);
    end
    sh = {32'd0, v} << (32 - int'(e_nxt));
  end

  always_ff @(posedge clk) begin
    e1_r <= e_nxt;
    f1_r <= sh[31:0];
  end

  // stage 2: table index and interpolation weight
  logic [31+AW:0] pm;
  logic [EW-1:0]  e2_r;
  logic [AW-1:0]  idx2_r;
  logic [31:0]    rem2_r;

  assign pm = (32+AW)'(f1_r) * (32+AW)'(NV);

  always_ff @(posedge clk) begin
    e2_r   <= e1_r;
    idx2_r <= pm[31+AW:32];
    rem2_r <= pm[31:0];
  end

  // stage 3: table lookup
  logic [EW-1:0]      e3_r;
  logic [31:0]        rem3_r;
  logic [FRAC_BITS:0] la3_r;
  logic [FRAC_BITS:0] lb3_r;

  always_ff @(posedge clk) begin
    e3_r   <= e2_r;
    rem3_r <= rem2_r;
    la3_r  <= lt_rom[idx2_r];
    lb3_r  <= lt_rom[idx2_r + AW'(1)];
  end

  // stage 4: interpolate
  logic [FRAC_BITS:0]    dl;
  logic [FRAC_BITS+32:0] dp;
  logic [LW-1:0]         log_r;

  assign dl = lb3_r - la3_r;
  assign dp = (FRAC_BITS+33)'(dl) * (FRAC_BITS+33)'(rem3_r);

  always_ff @(posedge clk) begin
    log_r <= {e3_r, {FRAC_BITS{1'b0}}} + LW'(la3_r) + LW'(dp[FRAC_BITS+32:32]);
  end

  assign log_out = log_r;

endmodule

// ===== hdl/pressure_to_altitude.sv =====
// Throughput: one sample per cycle; busy stays low, the pipeline never stalls.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset (rst_n low, synchronous) empties the pipeline and restores the three
// configuration registers to their defaults; the log/exp tables are constants.
module pressure_to_altitude #(
  parameter int LOG_TABLE_ENTRIES = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [p2a_pkg::PW-1:0]           in_pressure,
  // results
  output logic                             out_valid,
  output logic signed [p2a_pkg::OW-1:0]    out_absolute_altitude,
  output logic signed [p2a_pkg::OW-1:0]    out_relative_altitude,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import p2a_pkg::*;

  localparam int AW  = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int LW  = FRAC_BITS + EW;      // log2 value, unsigned
  localparam int DW  = FRAC_BITS + 6;       // log difference, signed
  localparam int PRW = DW + 29;             // d * K
  localparam int XW  = FRAC_BITS + 4;       // exponent, |x| < 3.3 in Q(F)
  localparam int VW  = FRAC_BITS + 2;       // 2^frac, up to 2.0
  localparam int SW  = FRAC_BITS + 9;       // shifted power
  localparam int MW  = FRAC_BITS + 6;       // power - 1, signed
  localparam int TAW = 28;                  // Tabs * 2000, signed
  localparam int QW  = TAW + MW;            // altitude numerator
  localparam int NST = 16;                  // pipeline stages

  localparam logic [AW-1:0]        NV     = AW'(LOG_TABLE_ENTRIES);
  localparam logic [AW-1:0]        IDXMAX = AW'(LOG_TABLE_ENTRIES - 1);
  localparam logic signed [28:0]   K_S    = {1'b0, K_EXP};
  localparam logic signed [MW-1:0] ONE_F  = MW'(64'd1 << FRAC_BITS);

  // ------------------------------------------------------------------
  // Exp table: 2^(i/N) in Q(F), i = 0..N
  // ------------------------------------------------------------------
  logic [VW-1:0] et_rom [0:LOG_TABLE_ENTRIES];

  for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_et
    localparam logic [63:0] Q = (64'(gi) << 30) / LOG_TABLE_ENTRIES;
    localparam logic [63:0] VAL = (gi == LOG_TABLE_ENTRIES) ?
                                  (64'd2 << FRAC_BITS) : et_from_q(Q, FRAC_BITS);
    assign et_rom[gi] = VAL[VW-1:0];
  end

  // ------------------------------------------------------------------
  // Configuration registers. Writes only happen while no transaction is in
  // flight: the user must keep to this, the block itself does not enforce it. The stages read them directly.
  // ------------------------------------------------------------------
  logic [PW-1:0] slp_r;
  logic [TW-1:0] tref_r;
  logic [GW-1:0] goff_r;
  logic          cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slp_r  <= SLP_RST;
      tref_r <= TREF_RST;
      goff_r <= GOFF_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SLP:  slp_r  <= pwdata[PW-1:0];
        REG_TREF: tref_r <= pwdata[TW-1:0];
        REG_GOFF: goff_r <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLP:  prdata = 32'(slp_r);
      REG_TREF: prdata = 32'(tref_r);
      REG_GOFF: prdata = 32'(goff_r);
      default:  prdata = '0;
    endcase
  end

  // Absolute temperature (0.01 K) times the cm scale; positive for any code.
  logic signed [TAW-1:0] tabs2000_r;
  int                    tabs_i;

  assign tabs_i = int'($signed(tref_r)) + KELVIN_OFS;

  always_ff @(posedge clk) begin
    tabs2000_r <= TAW'(tabs_i * CM_SCALE);
  end

  // ------------------------------------------------------------------
  // Valid and no-reading flags ride along with the data; index n marks the
  // flag that belongs with the data registered in stage n.
  // ------------------------------------------------------------------
  logic [NST-1:0] vld_r;
  logic [NST-1:0] pz_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], start && !busy};
    end
    pz_r <= {pz_r[NST-2:0], in_pressure == '0};
  end

  // stage 0: capture the sample
  logic [PW-1:0] p0_r;

  always_ff @(posedge clk) begin
    p0_r <= in_pressure;
  end

  // stages 1-4: log2 of the sample and of the reference, in parallel
  logic [LW-1:0] lp;
  logic [LW-1:0] lr;

  p2a_log2 #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES),
    .FRAC_BITS(FRAC_BITS)
  ) u_log_p (
    .clk    (clk),
    .v      (p0_r),
    .log_out(lp)
  );

  p2a_log2 #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES),
    .FRAC_BITS(FRAC_BITS)
  ) u_log_r (
    .clk    (clk),
    .v      (slp_r),
    .log_out(lr)
  );

  // stage 5: d = log2(Pref) - log2(P)
  logic signed [DW-1:0] d5_r;

  always_ff @(posedge clk) begin
    d5_r <= $signed(DW'(lr)) - $signed(DW'(lp));
  end

  // stage 6: scale by the exponent 0.190295
  logic signed [PRW-1:0] dk6_r;

  always_ff @(posedge clk) begin
    dk6_r <= d5_r * K_S;
  end

  // stage 7: split x into integer and fraction, pick the exp table slot.
  // Dropping the low 30 bits of a signed value is a floor shift.
  logic [XW-1:0]           x7;
  logic [FRAC_BITS+AW-1:0] pr7;
  logic [AW-1:0]           idx7;
  logic signed [3:0]       ip7_r;
  logic [AW-1:0]           idx7_r;
  logic [FRAC_BITS-1:0]    rem7_r;

  always_comb begin
    x7   = dk6_r[EXP_SHIFT+XW-1:EXP_SHIFT];
    pr7  = (FRAC_BITS+AW)'(x7[FRAC_BITS-1:0]) * (FRAC_BITS+AW)'(NV);
    idx7 = pr7[FRAC_BITS+AW-1:FRAC_BITS];
    if (idx7 > IDXMAX) idx7 = IDXMAX;
  end

  always_ff @(posedge clk) begin
    ip7_r  <= $signed(x7[XW-1:FRAC_BITS]);
    idx7_r <= idx7;
    rem7_r <= pr7[FRAC_BITS-1:0];
  end

  // stage 8: exp table lookup
  logic signed [3:0]    ip8_r;
  logic [FRAC_BITS-1:0] rem8_r;
  logic [VW-1:0]        ea8_r;
  logic [VW-1:0]        eb8_r;

  always_ff @(posedge clk) begin
    ip8_r  <= ip7_r;
    rem8_r <= rem7_r;
    ea8_r  <= et_rom[idx7_r];
    eb8_r  <= et_rom[idx7_r + AW'(1)];
  end

  // stage 9: interpolate 2^frac
  logic [VW-1:0]           de9;
  logic [VW+FRAC_BITS-1:0] dp9;
  logic signed [3:0]       ip9_r;
  logic [VW-1:0]           val9_r;

  assign de9 = eb8_r - ea8_r;
  assign dp9 = (VW+FRAC_BITS)'(de9) * (VW+FRAC_BITS)'(rem8_r);

  always_ff @(posedge clk) begin
    ip9_r  <= ip8_r;
    val9_r <= ea8_r + dp9[VW+FRAC_BITS-1:FRAC_BITS];
  end

  // stage 10: apply the integer exponent, subtract one.
  // A zero reference means a zero ratio, so the power is zero.
  logic [SW-1:0]        pow10;
  logic [3:0]           nsh10;
  logic signed [MW-1:0] m10_r;

  always_comb begin
    nsh10 = 4'(-ip9_r);
    if (slp_r == '0) begin
      pow10 = '0;
    end else if (ip9_r >= 0) begin
      pow10 = SW'(val9_r) << ip9_r[2:0];
    end else begin
      pow10 = SW'(val9_r) >> nsh10;
    end
  end

  always_ff @(posedge clk) begin
    m10_r <= $signed(MW'(pow10)) - ONE_F;
  end

  // stage 11: Tabs * 2000 * m
  logic signed [QW-1:0] prod11_r;

  always_ff @(posedge clk) begin
    prod11_r <= tabs2000_r * m10_r;
  end

  // stage 12: magnitude over 2^F (truncation toward zero is kept by
  // dividing the magnitude and restoring the sign later)
  logic [QW-1:0] mag12;
  logic          neg12_r;
  logic [31:0]   b12_r;

  assign mag12 = prod11_r[QW-1] ? QW'(-prod11_r) : QW'(prod11_r);

  always_ff @(posedge clk) begin
    neg12_r <= prod11_r[QW-1];
    b12_r   <= mag12[FRAC_BITS+31:FRAC_BITS];
  end

  // stage 13: divide by 13 through the reciprocal
  logic [63:0] r13;
  logic        neg13_r;
  logic [29:0] q13_r;

  assign r13 = 64'(b12_r) * 64'(DIV13_MAGIC);

  always_ff @(posedge clk) begin
    neg13_r <= neg12_r;
    q13_r   <= r13[63:DIV13_SHIFT];
  end

  // stage 14: sign and clamp of the absolute altitude
  int                   sv14;
  logic signed [OW-1:0] abs14_r;

  always_comb begin
    sv14 = neg13_r ? -int'(q13_r) : int'(q13_r);
    if (sv14 < ABS_LO) sv14 = ABS_LO;
    else if (sv14 > ABS_HI) sv14 = ABS_HI;
  end

  always_ff @(posedge clk) begin
    abs14_r <= OW'(sv14);
  end

  // stage 15: relative altitude from the clamped absolute one; a missing
  // reading forces both to zero
  int                   rv15;
  logic signed [OW-1:0] abs_out_r;
  logic signed [OW-1:0] rel_out_r;

  always_comb begin
    rv15 = int'(abs14_r) - int'($signed(goff_r));
    if (rv15 < REL_LO) rv15 = REL_LO;
    else if (rv15 > REL_HI) rv15 = REL_HI;
  end

  always_ff @(posedge clk) begin
    if (pz_r[NST-2]) begin
      abs_out_r <= '0;
      rel_out_r <= '0;
    end else begin
      abs_out_r <= abs14_r;
      rel_out_r <= OW'(rv15);
    end
  end

  assign out_valid             = vld_r[NST-1];
  assign out_absolute_altitude = abs_out_r;
  assign out_relative_altitude = rel_out_r;

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, NST))
    else $error("result strobe without a matching accepted transaction");

  a_no_reading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && pz_r[NST-1]) |->
      (out_absolute_altitude == '0 && out_relative_altitude == '0))
    else $error("zero pressure did not give zero altitudes");

  a_abs_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_absolute_altitude) >= ABS_LO &&
                   int'(out_absolute_altitude) <= ABS_HI))
    else $error("absolute altitude outside its clamp range");

  a_rel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_relative_altitude) >= REL_LO &&
                   int'(out_relative_altitude) <= REL_HI))
    else $error("relative altitude outside its clamp range");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Pressure-to-altitude checker: the scoreboard class keeps its own copy of
// the three configuration registers and of the log2/exp2 tables, works out
// both altitudes for every accepted sample, and compares them with the
// strobed results in order.
class altitude_scoreboard;
  typedef struct {
    logic signed [p2a_pkg::OW-1:0] abs_alt;
    logic signed [p2a_pkg::OW-1:0] rel_alt;
  } altitude_t;

  localparam int N = 256;
  localparam int F = 16;

  longint unsigned log_tab [0:N];
  longint unsigned exp_tab [0:N];
  longint unsigned root_tab [0:30];

  logic [p2a_pkg::PW-1:0] slp;
  logic [p2a_pkg::TW-1:0] tref;
  logic [p2a_pkg::GW-1:0] goff;

  altitude_t pending [$];
  int errors;

  function new();
    longint unsigned q, x, r, y, v, b, acc;
    root_tab[0] = 64'd2 << 30;
    for (int k = 1; k <= 30; k++) begin
      // floor square root, bit by bit
      v = root_tab[k-1] << 30;
      acc = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= acc + b) begin
          v = v - (acc + b);
          acc = (acc >> 1) + b;
        end else begin
          acc = acc >> 1;
        end
        b = b >> 2;
      end
      root_tab[k] = acc;
    end
    for (int i = 0; i < N; i++) begin
      q = (longint'(i) << 30) / N;
      x = (64'd1 << 30) + q;
      r = 0;
      for (int k = F - 1; k >= 0; k--) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          r = r | (64'd1 << k);
        end
      end
      log_tab[i] = r;
      y = 64'd1 << 30;
      for (int k = 1; k <= 30; k++)
        if (q[30-k]) y = (y * root_tab[k]) >> 30;
      exp_tab[i] = y >> (30 - F);
    end
    log_tab[N] = 64'd1 << F;
    exp_tab[N] = 64'd2 << F;
    slp = p2a_pkg::SLP_RST;
    tref = p2a_pkg::TREF_RST;
    goff = p2a_pkg::GOFF_RST;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      p2a_pkg::REG_SLP:  slp = val[p2a_pkg::PW-1:0];
      p2a_pkg::REG_TREF: tref = val[p2a_pkg::TW-1:0];
      p2a_pkg::REG_GOFF: goff = val[p2a_pkg::GW-1:0];
      default: ;
    endcase
  endfunction

  // log2 in Q16 with truncated table interpolation
  function longint unsigned log2_q(longint unsigned v);
    int e;
    longint unsigned frac, prod, idx, rem;
    e = 0;
    while (e < 31 && (v >> (e + 1)) != 0) e++;
    frac = (v << (32 - e)) & 64'hFFFF_FFFF;
    prod = frac * N;
    idx = prod >> 32;
    rem = prod & 64'hFFFF_FFFF;
    return (longint'(e) << F) + log_tab[idx] +
           (((log_tab[idx+1] - log_tab[idx]) * rem) >> 32);
  endfunction

  function void note_sample(logic [p2a_pkg::PW-1:0] p);
    altitude_t a;
    longint d, x, ip, pw, m, tabs, absv, relv;
    longint unsigned fr, prod, idx, rem, val;
    if (p == 0) begin
      a.abs_alt = 0;
      a.rel_alt = 0;
    end else begin
      if (slp == 0) begin
        pw = 0;
      end else begin
        d = longint'(log2_q(slp)) - longint'(log2_q(p));
        x = (d * 64'sd204327654) >>> 30;
        ip = x >>> F;
        fr = x - (ip << F);
        prod = fr * N;
        idx = prod >> F;
        rem = prod & ((64'd1 << F) - 1);
        if (idx > N - 1) idx = N - 1;
        val = exp_tab[idx] + (((exp_tab[idx+1] - exp_tab[idx]) * rem) >> F);
        if (ip >= 0) val = (ip > 20) ? (val << 20) : (val << ip);
        else val = (-ip > 40) ? 0 : (val >> (-ip));
        pw = val;
      end
      m = pw - (64'sd1 << F);
      tabs = longint'($signed(tref)) + 27315;
      absv = (tabs * 2000 * m) / (64'sd13 << F);
      if (absv < -200000) absv = -200000;
      if (absv > 5000000) absv = 5000000;
      relv = absv - longint'($signed(goff));
      if (relv < -5000000) relv = -5000000;
      if (relv > 5000000) relv = 5000000;
      a.abs_alt = absv[p2a_pkg::OW-1:0];
      a.rel_alt = relv[p2a_pkg::OW-1:0];
    end
    pending.push_back(a);
  endfunction

  function void check_result(logic [p2a_pkg::OW-1:0] abs_got,
                             logic [p2a_pkg::OW-1:0] rel_got);
    altitude_t a;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result abs=%0d rel=%0d",
                                 $signed(abs_got), $signed(rel_got));
      return;
    end
    a = pending.pop_front();
    if (abs_got !== a.abs_alt || rel_got !== a.rel_alt) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: abs exp %0d got %0d, rel exp %0d got %0d",
                 a.abs_alt, $signed(abs_got), a.rel_alt, $signed(rel_got));
    end
  endfunction
endclass

module testbench;
  import p2a_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [PW-1:0] in_pressure = '0;
  logic out_valid;
  logic signed [OW-1:0] out_absolute_altitude;
  logic signed [OW-1:0] out_relative_altitude;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  altitude_scoreboard alt_sb = new();
  int cycles = 0;
  bit quiet_tail = 0;  // no input gaps in the last phase

  pressure_to_altitude dut (.*);

  always #5 clk = ~clk;

  // Monitor: transactions are sampled at the rising edge, inputs change
  // only through nonblocking assignments at the same edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) alt_sb.note_sample(in_pressure);
      if (out_valid) alt_sb.check_result(out_absolute_altitude, out_relative_altitude);
      // a completed APB write updates the shadow registers
      if (psel && penable && pwrite && pready) alt_sb.write_reg(paddr[3:2], pwdata);
    end
    if (cycles >= LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // One sample transaction, optionally preceded by a random idle burst.
  // start stays high between back-to-back samples.
  task automatic send_pressure(logic [PW-1:0] p);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1;
    in_pressure <= p;
    do @(posedge clk); while (busy);
  endtask

  // Let the pipeline drain before touching registers.
  task automatic drain();
    start <= 0;
    while (alt_sb.pending.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic random_burst(int count);
    logic [PW-1:0] p;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: p = PW'($urandom);                          // any bit pattern
        1: p = PW'($urandom_range(0, 16));             // tiny and zero readings
        2: p = PW'(17'h1FFFF - $urandom_range(0, 16)); // top of the field
        default: p = PW'($urandom_range(30000, 120000));
      endcase
      send_pressure(p);
    end
  endtask

  task automatic set_regs(logic [31:0] slp_v, logic [31:0] tref_v, logic [31:0] goff_v);
    apb_write(REG_SLP, slp_v);
    apb_write(REG_TREF, tref_v);
    apb_write(REG_GOFF, goff_v);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes, no reading, equal to reference, bit walk
    send_pressure(0);
    send_pressure(1);
    send_pressure(17'h1FFFF);
    send_pressure(120000);
    send_pressure(30000);
    send_pressure(101325);
    send_pressure(2);
    for (int b = 2; b < PW; b++) send_pressure(17'd1 << b);
    drain();

    // zero reference pressure, extreme temperatures and offsets
    set_regs(0, 32'h3FFF, 32'hF_FFFF);
    send_pressure(0);
    send_pressure(50000);
    send_pressure(17'h1FFFF);
    random_burst(150);
    drain();

    set_regs(17'h1FFFF, 32'hFFFF_C000, 32'hFFF0_0000);
    random_burst(250);
    drain();

    set_regs(30000, -4000, -50000);
    random_burst(250);
    drain();

    set_regs(120000, 8500, 900000);
    random_burst(250);
    drain();

    set_regs(1, 0, 32'h1F_FFFF);
    random_burst(150);
    drain();

    repeat (3) begin
      set_regs($urandom_range(30000, 120000), $urandom_range(0, 12500) - 4000,
               $urandom_range(0, 950000) - 50000);
      random_burst(200);
      drain();
    end

    // last stretch runs back to back
    set_regs(101325, 1500, 0);
    quiet_tail = 1;
    random_burst(280);
    drain();

    if (alt_sb.errors == 0 && alt_sb.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
